@@ src/arpc_pkg.sv @@
// arpc_pkg: shared types and codes of the arp cache engine
// item structs, memory entry layouts, op and status codes; no dependencies
package arpc_pkg;

  localparam int unsigned CACHE_ENTRIES_DEF   = 16;
  localparam int unsigned PENDING_ENTRIES_DEF = 8;

  // op codes of an input beat
  localparam logic [2:0] OP_RX       = 3'd0;
  localparam logic [2:0] OP_LOOKUP   = 3'd1;
  localparam logic [2:0] OP_ADD_PEND = 3'd2;
  localparam logic [2:0] OP_DELETE   = 3'd3;
  localparam logic [2:0] OP_CLEAR    = 3'd4;

  // arp opcodes
  localparam logic [15:0] ARP_OP_REQ  = 16'd1;
  localparam logic [15:0] ARP_OP_RESP = 16'd2;

  // result status codes
  localparam logic [1:0] ST_DONE       = 2'd0;
  localparam logic [1:0] ST_CACHE_FULL = 2'd1;
  localparam logic [1:0] ST_PEND_FULL  = 2'd2;
  localparam logic [1:0] ST_BAD_OPCODE = 2'd3;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] arp_opcode;
    logic [31:0] sender_ip;
    logic [47:0] sender_mac;
    logic [31:0] target_ip;
    logic [31:0] query_ip;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        hit;
    logic [47:0] found_mac;
    logic        pending;
    logic        send_reply;
    logic [47:0] reply_mac;
    logic [31:0] reply_ip;
  } out_item_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] ip;
    logic [47:0] mac;
  } cache_entry_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] ip;
  } pend_entry_t;

endpackage

@@ src/arpc_ram.sv @@
// arpc_ram: single-port-write, single-port-read synchronous memory
// registered read data; no package dependency
module arpc_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/arpc_ctrl.sv @@
// arpc_ctrl: scan sequencer, read-modify-write control and result register
// uses arpc_pkg; drives the cache and pending memories
module arpc_ctrl
  import arpc_pkg::*;
#(
  parameter int unsigned CACHE_ENTRIES   = CACHE_ENTRIES_DEF,
  parameter int unsigned PENDING_ENTRIES = PENDING_ENTRIES_DEF,
  localparam int unsigned CW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1,
  localparam int unsigned PW = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [31:0]  cfg_data_i,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  in_item_t     in_data_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output out_item_t    out_data_o,
  output logic         cache_we_o,
  output logic [CW-1:0] cache_waddr_o,
  output cache_entry_t cache_wdata_o,
  output logic [CW-1:0] cache_raddr_o,
  input  cache_entry_t cache_rdata_i,
  output logic         pend_we_o,
  output logic [PW-1:0] pend_waddr_o,
  output pend_entry_t  pend_wdata_o,
  output logic [PW-1:0] pend_raddr_o,
  input  pend_entry_t  pend_rdata_i
);

  localparam int unsigned ScanLen = (CACHE_ENTRIES > PENDING_ENTRIES) ?
                                    CACHE_ENTRIES : PENDING_ENTRIES;
  localparam int unsigned NW = $clog2(ScanLen) + 1;

  typedef enum logic [1:0] {S_INIT, S_IDLE, S_SCAN, S_COMMIT} state_e;

  state_e       state_q, state_d;
  logic [NW-1:0] idx_q, idx_d;
  logic         cmp_vld_q, cmp_vld_d;
  logic [NW-1:0] cmp_idx_q, cmp_idx_d;
  in_item_t     item_q, item_d;
  logic [31:0]  local_ip_q, local_ip_d;
  logic         c_hit_q, c_hit_d;
  logic [CW-1:0] c_hit_idx_q, c_hit_idx_d;
  logic [47:0]  c_mac_q, c_mac_d;
  logic         c_free_q, c_free_d;
  logic [CW-1:0] c_free_idx_q, c_free_idx_d;
  logic         p_hit_q, p_hit_d;
  logic [PW-1:0] p_hit_idx_q, p_hit_idx_d;
  logic         p_free_q, p_free_d;
  logic [PW-1:0] p_free_idx_q, p_free_idx_d;
  logic         out_valid_q, out_valid_d;
  out_item_t    out_q, out_d;

  logic         idx_in_cache, idx_in_pend, cmp_in_cache, cmp_in_pend;
  logic [31:0]  key;
  logic         is_arp;

  assign idx_in_cache = idx_q < NW'(CACHE_ENTRIES);
  assign idx_in_pend  = idx_q < NW'(PENDING_ENTRIES);
  assign cmp_in_cache = cmp_idx_q < NW'(CACHE_ENTRIES);
  assign cmp_in_pend  = cmp_idx_q < NW'(PENDING_ENTRIES);
  assign key    = (item_q.op == OP_RX) ? item_q.sender_ip : item_q.query_ip;
  assign is_arp = (item_q.arp_opcode == ARP_OP_REQ) || (item_q.arp_opcode == ARP_OP_RESP);

  // out-of-range scan slots read entry zero and are ignored
  assign cache_raddr_o = idx_in_cache ? idx_q[CW-1:0] : '0;
  assign pend_raddr_o  = idx_in_pend ? idx_q[PW-1:0] : '0;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    cmp_vld_d    = cmp_vld_q;
    cmp_idx_d    = cmp_idx_q;
    item_d       = item_q;
    local_ip_d   = cfg_valid_i ? cfg_data_i : local_ip_q;
    c_hit_d      = c_hit_q;
    c_hit_idx_d  = c_hit_idx_q;
    c_mac_d      = c_mac_q;
    c_free_d     = c_free_q;
    c_free_idx_d = c_free_idx_q;
    p_hit_d      = p_hit_q;
    p_hit_idx_d  = p_hit_idx_q;
    p_free_d     = p_free_q;
    p_free_idx_d = p_free_idx_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;

    cache_we_o    = 1'b0;
    cache_waddr_o = idx_q[CW-1:0];
    cache_wdata_o = '0;
    pend_we_o     = 1'b0;
    pend_waddr_o  = idx_q[PW-1:0];
    pend_wdata_o  = '0;

    case (state_q)
      S_INIT: begin
        // clearing pass over both memories after reset
        cache_we_o = idx_in_cache;
        pend_we_o  = idx_in_pend;
        if (idx_q == NW'(ScanLen - 1)) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + NW'(1);
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          item_d    = in_data_i;
          idx_d     = '0;
          cmp_vld_d = 1'b0;
          c_hit_d   = 1'b0;
          c_free_d  = 1'b0;
          p_hit_d   = 1'b0;
          p_free_d  = 1'b0;
          state_d   = S_SCAN;
        end
      end
      S_SCAN: begin
        if (idx_q != NW'(ScanLen)) begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = idx_q;
          idx_d     = idx_q + NW'(1);
          // clear sweeps the cache valid flags while the scan runs
          cache_we_o = (item_q.op == OP_CLEAR) && idx_in_cache;
        end else begin
          cmp_vld_d = 1'b0;
        end
        if (cmp_vld_q) begin
          if (cmp_in_cache) begin
            if (cache_rdata_i.valid && cache_rdata_i.ip == key && !c_hit_q) begin
              c_hit_d     = 1'b1;
              c_hit_idx_d = cmp_idx_q[CW-1:0];
              c_mac_d     = cache_rdata_i.mac;
            end
            if (!cache_rdata_i.valid && !c_free_q) begin
              c_free_d     = 1'b1;
              c_free_idx_d = cmp_idx_q[CW-1:0];
            end
          end
          if (cmp_in_pend) begin
            if (pend_rdata_i.valid && pend_rdata_i.ip == key && !p_hit_q) begin
              p_hit_d     = 1'b1;
              p_hit_idx_d = cmp_idx_q[PW-1:0];
            end
            if (!pend_rdata_i.valid && !p_free_q) begin
              p_free_d     = 1'b1;
              p_free_idx_d = cmp_idx_q[PW-1:0];
            end
          end
          if (cmp_idx_q == NW'(ScanLen - 1)) begin
            state_d = S_COMMIT;
          end
        end
      end
      S_COMMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = '0;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
          case (item_q.op)
            OP_RX: begin
              if (is_arp) begin
                cache_we_o          = c_hit_q || c_free_q;
                cache_waddr_o       = c_hit_q ? c_hit_idx_q : c_free_idx_q;
                cache_wdata_o.valid = 1'b1;
                cache_wdata_o.ip    = item_q.sender_ip;
                cache_wdata_o.mac   = item_q.sender_mac;
                if (!c_hit_q && !c_free_q) begin
                  out_d.status = ST_CACHE_FULL;
                end
                if (item_q.arp_opcode == ARP_OP_REQ && item_q.target_ip == local_ip_q) begin
                  out_d.send_reply = 1'b1;
                  out_d.reply_mac  = item_q.sender_mac;
                  out_d.reply_ip   = item_q.sender_ip;
                end
                // a reply retires the first matching pending request
                if (item_q.arp_opcode == ARP_OP_RESP && p_hit_q) begin
                  pend_we_o    = 1'b1;
                  pend_waddr_o = p_hit_idx_q;
                end
              end else begin
                out_d.status = ST_BAD_OPCODE;
              end
            end
            OP_LOOKUP: begin
              out_d.hit       = c_hit_q;
              out_d.found_mac = c_hit_q ? c_mac_q : '0;
              out_d.pending   = p_hit_q;
            end
            OP_ADD_PEND: begin
              if (p_free_q) begin
                pend_we_o          = 1'b1;
                pend_waddr_o       = p_free_idx_q;
                pend_wdata_o.valid = 1'b1;
                pend_wdata_o.ip    = item_q.query_ip;
              end else begin
                out_d.status = ST_PEND_FULL;
              end
            end
            OP_DELETE: begin
              cache_we_o    = c_hit_q;
              cache_waddr_o = c_hit_idx_q;
            end
            default: begin
              out_d.status = ST_DONE;
            end
          endcase
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      idx_q        <= '0;
      cmp_vld_q    <= 1'b0;
      cmp_idx_q    <= '0;
      item_q       <= '0;
      local_ip_q   <= '0;
      c_hit_q      <= 1'b0;
      c_hit_idx_q  <= '0;
      c_mac_q      <= '0;
      c_free_q     <= 1'b0;
      c_free_idx_q <= '0;
      p_hit_q      <= 1'b0;
      p_hit_idx_q  <= '0;
      p_free_q     <= 1'b0;
      p_free_idx_q <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      cmp_vld_q    <= cmp_vld_d;
      cmp_idx_q    <= cmp_idx_d;
      item_q       <= item_d;
      local_ip_q   <= local_ip_d;
      c_hit_q      <= c_hit_d;
      c_hit_idx_q  <= c_hit_idx_d;
      c_mac_q      <= c_mac_d;
      c_free_q     <= c_free_d;
      c_free_idx_q <= c_free_idx_d;
      p_hit_q      <= p_hit_d;
      p_hit_idx_q  <= p_hit_idx_d;
      p_free_q     <= p_free_d;
      p_free_idx_q <= p_free_idx_d;
      out_valid_q  <= out_valid_d;
      out_q        <= out_d;
    end
  end

endmodule

@@ src/arp_cache_engine.sv @@
// arp_cache_engine: top level, ipv4-to-mac cache with pending request list
// uses arpc_pkg, arpc_ram and arpc_ctrl
//
// Every input beat scans the cache memory and the pending memory in parallel, one
// entry per cycle through their registered read ports, then commits at most one write
// to each and loads the result register; the commit waits while an earlier result
// is not yet taken, but a new item is taken while the previous result still waits.
// After reset a clearing pass over both memories runs with in_ready_o low; local_ip
// writes on the cfg channel are taken at any time.
module arp_cache_engine
  import arpc_pkg::*;
#(
  parameter int unsigned CACHE_ENTRIES   = CACHE_ENTRIES_DEF,
  parameter int unsigned PENDING_ENTRIES = PENDING_ENTRIES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int unsigned CW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int unsigned PW = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;

  logic         cache_we;
  logic [CW-1:0] cache_waddr, cache_raddr;
  cache_entry_t cache_wdata, cache_rdata;
  logic         pend_we;
  logic [PW-1:0] pend_waddr, pend_raddr;
  pend_entry_t  pend_wdata, pend_rdata;

  arpc_ctrl #(
    .CACHE_ENTRIES  (CACHE_ENTRIES),
    .PENDING_ENTRIES(PENDING_ENTRIES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o),
    .cache_we_o   (cache_we),
    .cache_waddr_o(cache_waddr),
    .cache_wdata_o(cache_wdata),
    .cache_raddr_o(cache_raddr),
    .cache_rdata_i(cache_rdata),
    .pend_we_o    (pend_we),
    .pend_waddr_o (pend_waddr),
    .pend_wdata_o (pend_wdata),
    .pend_raddr_o (pend_raddr),
    .pend_rdata_i (pend_rdata)
  );

  arpc_ram #(
    .DEPTH(CACHE_ENTRIES),
    .WIDTH($bits(cache_entry_t))
  ) u_cache_ram (
    .clk_i  (clk_i),
    .we_i   (cache_we),
    .waddr_i(cache_waddr),
    .wdata_i(cache_wdata),
    .raddr_i(cache_raddr),
    .rdata_o(cache_rdata)
  );

  arpc_ram #(
    .DEPTH(PENDING_ENTRIES),
    .WIDTH($bits(pend_entry_t))
  ) u_pend_ram (
    .clk_i  (clk_i),
    .we_i   (pend_we),
    .waddr_i(pend_waddr),
    .wdata_i(pend_wdata),
    .raddr_i(pend_raddr),
    .rdata_o(pend_rdata)
  );

endmodule

@@ src/arpc_chk.sv @@
// arpc_chk: port-level checks of the arp cache engine, bound to the top level
// uses arpc_pkg
module arpc_chk
  import arpc_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  // a result beat holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed before it was taken");

  // one item at a time: the scan starts right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a scan was running");

  // lookup fields and reply fields never come from the same op
  a_lookup_vs_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.send_reply && (out_data_o.hit || out_data_o.pending)))
    else $error("lookup and reply fields set together");

  // a miss or a non-lookup carries no mac
  a_mac_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.hit |-> out_data_o.found_mac == 48'd0)
    else $error("found_mac set without a hit");

  a_reply_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.send_reply |->
      out_data_o.reply_mac == 48'd0 && out_data_o.reply_ip == 32'd0)
    else $error("reply address set without a reply");

endmodule

bind arp_cache_engine arpc_chk u_arpc_chk (.*);

@@ bench/tb_arp_cache_engine.sv @@
// tb_arp_cache_engine: self-checking bench for the arp cache engine
// directed table then random ops, checked against typed rows or a local cache model
// depends on arpc_pkg and arp_cache_engine
module tb_arp_cache_engine;
  import arpc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CACHE_N     = CACHE_ENTRIES_DEF;
  localparam int PEND_N      = PENDING_ENTRIES_DEF;
  localparam int POOL_N      = 24;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    in_item_t  stim;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      cfg_valid   = 1'b0;
  logic      cfg_ready_o;
  logic [31:0] cfg_data  = '0;
  logic      in_valid    = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data     = '0;
  logic      out_valid_o;
  logic      out_ready   = 1'b0;
  out_item_t out_data_o;

  // local copy of the cache, the pending list and the register
  bit          cache_vld   [CACHE_N];
  logic [31:0] cache_ip_q  [CACHE_N];
  logic [47:0] cache_mac_q [CACHE_N];
  bit          pend_vld    [PEND_N];
  logic [31:0] pend_ip_q   [PEND_N];
  logic [31:0] local_ip_q  = '0;

  out_item_t   results_due [$];
  dir_row_t    dir_rows    [$];
  logic [31:0] ip_pool     [POOL_N];
  int          bad_results  = 0;
  int          items_sent   = 0;
  int          burst_left   = 0;
  int          quiet_cycles = 0;
  bit          gaps_on      = 1'b1;
  bit          hold_req     = 1'b0;

  arp_cache_engine u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  always #5ns clk_i = ~clk_i;

  function automatic int cache_slot_of(input logic [31:0] ip);
    for (int i = 0; i < CACHE_N; i++) begin
      if (cache_vld[i] && cache_ip_q[i] == ip) return i;
    end
    return -1;
  endfunction

  function automatic int free_cache_slot();
    for (int i = 0; i < CACHE_N; i++) begin
      if (!cache_vld[i]) return i;
    end
    return -1;
  endfunction

  function automatic int pend_slot_of(input logic [31:0] ip);
    for (int i = 0; i < PEND_N; i++) begin
      if (pend_vld[i] && pend_ip_q[i] == ip) return i;
    end
    return -1;
  endfunction

  function automatic int free_pend_slot();
    for (int i = 0; i < PEND_N; i++) begin
      if (!pend_vld[i]) return i;
    end
    return -1;
  endfunction

  // applies one beat to the local state and returns the result it must give
  function automatic out_item_t resolve_arp(input in_item_t it);
    out_item_t r;
    int        slot;
    r = '0;
    case (it.op)
      OP_RX: begin
        if (it.arp_opcode == ARP_OP_REQ || it.arp_opcode == ARP_OP_RESP) begin
          slot = cache_slot_of(it.sender_ip);
          if (slot < 0) slot = free_cache_slot();
          if (slot < 0) begin
            r.status = ST_CACHE_FULL;
          end else begin
            cache_vld[slot]   = 1'b1;
            cache_ip_q[slot]  = it.sender_ip;
            cache_mac_q[slot] = it.sender_mac;
          end
          if (it.arp_opcode == ARP_OP_REQ) begin
            // reply is ordered even when the insert was dropped
            if (it.target_ip == local_ip_q) begin
              r.send_reply = 1'b1;
              r.reply_mac  = it.sender_mac;
              r.reply_ip   = it.sender_ip;
            end
          end else begin
            slot = pend_slot_of(it.sender_ip);
            if (slot >= 0) pend_vld[slot] = 1'b0;
          end
        end else begin
          r.status = ST_BAD_OPCODE;
        end
      end
      OP_LOOKUP: begin
        slot = cache_slot_of(it.query_ip);
        if (slot >= 0) begin
          r.hit       = 1'b1;
          r.found_mac = cache_mac_q[slot];
        end
        r.pending = (pend_slot_of(it.query_ip) >= 0);
      end
      OP_ADD_PEND: begin
        slot = free_pend_slot();
        if (slot < 0) begin
          r.status = ST_PEND_FULL;
        end else begin
          pend_vld[slot]  = 1'b1;
          pend_ip_q[slot] = it.query_ip;
        end
      end
      OP_DELETE: begin
        slot = cache_slot_of(it.query_ip);
        if (slot >= 0) cache_vld[slot] = 1'b0;
      end
      OP_CLEAR: begin
        for (int i = 0; i < CACHE_N; i++) cache_vld[i] = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic in_item_t mk_item(input logic [2:0] op, input logic [15:0] opc,
                                       input logic [31:0] sip, input logic [47:0] smac,
                                       input logic [31:0] tip, input logic [31:0] qip);
    in_item_t it;
    it.op         = op;
    it.arp_opcode = opc;
    it.sender_ip  = sip;
    it.sender_mac = smac;
    it.target_ip  = tip;
    it.query_ip   = qip;
    return it;
  endfunction

  function automatic out_item_t mk_want(input logic [1:0] status, input logic reply,
                                        input logic [47:0] rmac, input logic [31:0] rip);
    out_item_t w;
    w            = '0;
    w.status     = status;
    w.send_reply = reply;
    w.reply_mac  = rmac;
    w.reply_ip   = rip;
    return w;
  endfunction

  function automatic void add_row(input in_item_t stim, input logic typed, input out_item_t want);
    dir_row_t row;
    row.stim  = stim;
    row.typed = typed;
    row.want  = want;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  // every field random, op fixed
  function automatic in_item_t rand_item(input logic [2:0] op);
    in_item_t    it;
    logic [63:0] w;
    w             = {$urandom, $urandom};
    it.op         = op;
    it.arp_opcode = 16'($urandom);
    it.sender_ip  = $urandom;
    it.sender_mac = w[47:0];
    it.target_ip  = $urandom;
    it.query_ip   = $urandom;
    return it;
  endfunction

  function automatic logic [31:0] pick_ip();
    if ($urandom_range(0, 99) < 88) return ip_pool[$urandom_range(0, POOL_N - 1)];
    return $urandom;
  endfunction

  function automatic in_item_t mix_item();
    in_item_t it;
    int       r;
    int       r2;
    r = $urandom_range(0, 99);
    if (r < 42) begin
      it = rand_item(OP_RX);
      r2 = $urandom_range(0, 99);
      if (r2 < 45) it.arp_opcode = ARP_OP_REQ;
      else if (r2 < 85) it.arp_opcode = ARP_OP_RESP;
      it.sender_ip = pick_ip();
      it.target_ip = $urandom_range(0, 1) ? local_ip_q : pick_ip();
    end else if (r < 66) begin
      it = rand_item(OP_LOOKUP);
      it.query_ip = pick_ip();
    end else if (r < 81) begin
      it = rand_item(OP_ADD_PEND);
      it.query_ip = pick_ip();
    end else if (r < 92) begin
      it = rand_item(OP_DELETE);
      it.query_ip = pick_ip();
    end else if (r < 95) begin
      it = rand_item(OP_CLEAR);
    end else begin
      it = rand_item(3'($urandom_range(5, 7)));
    end
    return it;
  endfunction

  task automatic offer_item(input in_item_t it, input logic typed, input out_item_t typed_want);
    out_item_t want;
    if (gaps_on && burst_left <= 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 22)) @(negedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    want = resolve_arp(it);
    results_due.insert(results_due.size(), typed ? typed_want : want);
    items_sent++;
    burst_left--;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_local_ip(input logic [31:0] value);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    local_ip_q = value;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // clear, fill every slot, overflow with a request that still wants a reply, then look up
  task automatic fill_cache_seq();
    in_item_t    it;
    logic [31:0] fresh [18];
    offer_item(rand_item(OP_CLEAR), 1'b0, '0);
    for (int k = 0; k < 18; k++) begin
      it = rand_item(OP_RX);
      it.arp_opcode = (k % 2) ? ARP_OP_RESP : ARP_OP_REQ;
      fresh[k] = it.sender_ip;
      if (k == 17) begin
        it.arp_opcode = ARP_OP_REQ;
        it.target_ip  = local_ip_q;
      end
      offer_item(it, 1'b0, '0);
    end
    it = rand_item(OP_RX);
    it.arp_opcode = ARP_OP_REQ;
    it.sender_ip  = fresh[3];
    offer_item(it, 1'b0, '0);
    it = rand_item(OP_LOOKUP);
    it.query_ip = fresh[3];
    offer_item(it, 1'b0, '0);
    it.query_ip = fresh[17];
    offer_item(it, 1'b0, '0);
  endtask

  // overfill the pending list from six addresses, then answer or look up some of them
  task automatic fill_pend_seq();
    in_item_t it;
    for (int k = 0; k < 10; k++) begin
      it = rand_item(OP_ADD_PEND);
      it.query_ip = ip_pool[$urandom_range(0, 5)];
      offer_item(it, 1'b0, '0);
    end
    for (int k = 0; k < 6; k++) begin
      it = rand_item($urandom_range(0, 1) ? OP_RX : OP_LOOKUP);
      it.arp_opcode = ARP_OP_RESP;
      it.sender_ip  = ip_pool[$urandom_range(0, 5)];
      it.query_ip   = ip_pool[$urandom_range(0, 5)];
      offer_item(it, 1'b0, '0);
    end
  endtask

  task automatic run_phase(input int quota, input logic fills_first);
    int done_at;
    int pick;
    done_at = items_sent + quota;
    if (fills_first) begin
      fill_cache_seq();
      fill_pend_seq();
    end
    while (items_sent < done_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        fill_cache_seq();
      end else if (pick < 24) begin
        fill_pend_seq();
      end else begin
        repeat ($urandom_range(20, 60)) offer_item(mix_item(), 1'b0, '0);
      end
    end
  endtask

  task automatic take_result(input out_item_t got);
    out_item_t want;
    if (results_due.size() == 0) begin
      if (bad_results < 10)
        $display("unexpected result beat: st=%0d hit=%0b fmac=%h pend=%0b rep=%0b rmac=%h rip=%h",
                 got.status, got.hit, got.found_mac, got.pending, got.send_reply,
                 got.reply_mac, got.reply_ip);
      bad_results++;
    end else begin
      want = results_due.pop_front();
      if (got.status !== want.status || got.hit !== want.hit ||
          got.found_mac !== want.found_mac || got.pending !== want.pending ||
          got.send_reply !== want.send_reply || got.reply_mac !== want.reply_mac ||
          got.reply_ip !== want.reply_ip) begin
        if (bad_results < 10) begin
          $display("mismatch at %0t expected: st=%0d hit=%0b fmac=%h pend=%0b rep=%0b rmac=%h rip=%h",
                   $realtime, want.status, want.hit, want.found_mac, want.pending,
                   want.send_reply, want.reply_mac, want.reply_ip);
          $display("                actual:   st=%0d hit=%0b fmac=%h pend=%0b rep=%0b rmac=%h rip=%h",
                   got.status, got.hit, got.found_mac, got.pending, got.send_reply,
                   got.reply_mac, got.reply_ip);
        end
        bad_results++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready) take_result(out_data_o);
  end

  // receiver: random stall patterns in windows, plus a long hold-off on request
  initial begin
    int          mode;
    logic [15:0] pat;
    forever begin
      mode = $urandom_range(0, 3);
      pat  = 16'($urandom);
      for (int k = 0; k < 64; k++) begin
        @(negedge clk_i);
        if (hold_req) begin
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk_i);
          hold_req = 1'b0;
        end else begin
          case (mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 3) != 0);
            2:       out_ready <= ($urandom_range(0, 2) == 0);
            default: out_ready <= pat[k % 16];
          endcase
        end
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  initial begin
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid && in_ready_o === 1'b1) ||
          (out_valid_o === 1'b1 && out_ready) || (cfg_valid && cfg_ready_o === 1'b1))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    dir_row_t    row;
    logic [31:0] lip;
    // local_ip is still at its reset value of zero here
    add_row(mk_item(OP_LOOKUP, '0, '0, '0, '0, 32'h0), 1'b1, '0);
    add_row(mk_item(OP_RX, ARP_OP_REQ, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'h0, 32'hFFFF_FFFF),
            1'b1, mk_want(ST_DONE, 1'b1, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF));
    add_row(mk_item(OP_RX, ARP_OP_RESP, 32'h0, 48'h0, 32'hFFFF_FFFF, 32'h0), 1'b1, '0);
    add_row(mk_item(OP_LOOKUP, '1, '1, '1, '1, 32'hFFFF_FFFF), 1'b0, '0);
    add_row(mk_item(OP_RX, ARP_OP_REQ, 32'hFFFF_FFFF, 48'h5A5A_C3C3_0F0F, 32'h1, 32'h0),
            1'b0, '0);
    add_row(mk_item(OP_LOOKUP, '0, '0, '0, '0, 32'hFFFF_FFFF), 1'b0, '0);
    add_row(mk_item(OP_RX, 16'h0, 32'h0A00_0001, 48'h1, 32'h0, 32'h0), 1'b1,
            mk_want(ST_BAD_OPCODE, 1'b0, '0, '0));
    add_row(mk_item(OP_RX, 16'hFFFF, 32'h0A00_0001, 48'h1, 32'h0, 32'h0), 1'b1,
            mk_want(ST_BAD_OPCODE, 1'b0, '0, '0));
    add_row(mk_item(OP_RX, 16'h3, 32'h0A00_0001, 48'h1, 32'h0, 32'h0), 1'b1,
            mk_want(ST_BAD_OPCODE, 1'b0, '0, '0));
    // the same address pending twice
    add_row(mk_item(OP_ADD_PEND, '0, '0, '0, '0, 32'h0A00_0001), 1'b1, '0);
    add_row(mk_item(OP_ADD_PEND, '0, '0, '0, '0, 32'h0A00_0001), 1'b1, '0);
    add_row(mk_item(OP_ADD_PEND, '0, '0, '0, '0, 32'h0C00_0003), 1'b1, '0);
    add_row(mk_item(OP_LOOKUP, '0, '0, '0, '0, 32'h0A00_0001), 1'b0, '0);
    add_row(mk_item(OP_RX, ARP_OP_RESP, 32'h0A00_0001, 48'h0000_1111_2222, '0, '0), 1'b0, '0);
    add_row(mk_item(OP_LOOKUP, '0, '0, '0, '0, 32'h0A00_0001), 1'b0, '0);
    add_row(mk_item(OP_RX, ARP_OP_RESP, 32'h0A00_0001, 48'h0000_3333_4444, '0, '0), 1'b0, '0);
    add_row(mk_item(OP_LOOKUP, '0, '0, '0, '0, 32'h0A00_0001), 1'b0, '0);
    add_row(mk_item(OP_RX, ARP_OP_RESP, 32'h0A00_00FF, 48'h8000_0000_0001, '0, '0), 1'b0, '0);
    add_row(mk_item(OP_DELETE, '0, '0, '0, '0, 32'h0A00_00FF), 1'b0, '0);
    add_row(mk_item(OP_DELETE, '0, '0, '0, '0, 32'h0B00_0000), 1'b0, '0);
    add_row(mk_item(OP_LOOKUP, '0, '0, '0, '0, 32'h0A00_00FF), 1'b0, '0);
    add_row(mk_item(3'd5, '1, '1, '1, '1, '1), 1'b1, '0);
    add_row(mk_item(3'd7, '1, '1, '1, '1, '1), 1'b1, '0);
    add_row(mk_item(OP_CLEAR, '0, '0, '0, '0, '0), 1'b1, '0);
    add_row(mk_item(OP_LOOKUP, '0, '0, '0, '0, 32'hFFFF_FFFF), 1'b0, '0);
    add_row(mk_item(OP_LOOKUP, '0, '0, '0, '0, 32'h0C00_0003), 1'b0, '0);

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int k = 0; k < dir_rows.size(); k++) begin
      row = dir_rows[k];
      offer_item(row.stim, row.typed, row.want);
    end

    for (int p = 0; p < 5; p++) begin
      drain();
      for (int i = 0; i < POOL_N - 2; i++) ip_pool[i] = $urandom;
      ip_pool[POOL_N - 2] = 32'h0;
      ip_pool[POOL_N - 1] = 32'hFFFF_FFFF;
      case (p)
        0:       lip = 32'hFFFF_FFFF;
        1:       lip = 32'h0;
        3:       lip = ip_pool[1];
        default: lip = $urandom;
      endcase
      write_local_ip(lip);
      if (p == 1 || p == 3) hold_req = 1'b1;
      gaps_on = (p != 2);
      run_phase(185, p == 0);
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (bad_results == 0 && results_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/arpc_pkg.sv
src/arpc_ram.sv
src/arpc_ctrl.sv
src/arp_cache_engine.sv
src/arpc_chk.sv
bench/tb_arp_cache_engine.sv
